### rtl/core/pipv4_pkg.sv
// Shared constants for the partial IPv4 address parser.
`default_nettype none
package pipv4_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned OctetW  = 10;
  localparam int unsigned RunW    = 2;
  localparam int unsigned OutW    = 1 + AddrW + PortW;
  localparam int unsigned OutTdW  = ((OutW + 7) / 8) * 8;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  localparam logic [CharW-1:0]  CharZero   = 8'h30;
  localparam logic [CharW-1:0]  CharNine   = 8'h39;
  localparam logic [CharW-1:0]  CharDot    = 8'h2E;
  localparam logic [CharW-1:0]  CharColon  = 8'h3A;
  localparam logic [CharW-1:0]  CharNul    = 8'h00;
  localparam logic [OctetW-1:0] OctetMax   = 10'd255;
  localparam logic [RunW-1:0]   RunMax     = 2'd3;

  localparam logic RegLocalAddr   = 1'b0;
  localparam logic RegDefaultPort = 1'b1;

endpackage
`default_nettype wire

### rtl/core/partial_ipv4_address_parser.sv
// Top level: dotted-decimal IPv4 address and port parser with an APB register port.
// Accepts one character per cycle while the input is not stalled;
// a result is registered once the character carrying tlast leaves the input register.
// The input register and the result register each hold one transaction.
// A last character waits in the input register while the result register is full.
// Reset clears the parse state, the APB registers and the input and result valid flags.
`default_nettype none
module partial_ipv4_address_parser
  import pipv4_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [CharW-1:0]  s_axis_tdata,   // char_code
  input  wire logic              s_axis_tlast,   // last_char
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OutTdW-1:0]      m_axis_tdata,   // parse_ok, ip_address, port_number, zero pad
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [1:0] {PH_START, PH_OCTET, PH_PORT, PH_SKIP} phase_e;

  logic [AddrW-1:0]  local_addr_q;
  logic [PortW-1:0]  default_port_q;

  logic              in_valid_q;
  logic [CharW-1:0]  in_char_q;
  logic              in_last_q;

  phase_e            phase_q, phase_d;
  logic [OctetW-1:0] octet_q, octet_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [AddrW-1:0]  accum_q, accum_d;
  logic [AddrW-1:0]  mask_q, mask_d;
  logic [PortW-1:0]  port_q, port_d;
  logic              err_q, err_d;
  logic              given_q, given_d;

  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic [AddrW-1:0]  out_ip_q, out_ip_d;
  logic [PortW-1:0]  out_port_q, out_port_d;

  logic              stall;
  logic              advance;
  logic              is_digit;
  logic [3:0]        digit;
  logic              do_close;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign prdata  = (paddr[2] == RegDefaultPort) ? {{(PdataW-PortW){1'b0}}, default_port_q}
                                                : local_addr_q;

  assign stall         = in_valid_q && in_last_q && out_valid_q && !m_axis_tready;
  assign advance       = in_valid_q && !stall;
  assign s_axis_tready = !in_valid_q || !stall;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdW-OutW){1'b0}}, out_port_q, out_ip_q, out_ok_q};

  assign is_digit = in_char_q inside {[CharZero:CharNine]};
  assign digit    = 4'(in_char_q - CharZero);

  always_comb begin
    phase_d    = phase_q;
    octet_d    = octet_q;
    run_d      = run_q;
    accum_d    = accum_q;
    mask_d     = mask_q;
    port_d     = port_q;
    err_d      = err_q;
    given_d    = given_q;
    do_close   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ok_d   = out_ok_q;
    out_ip_d   = out_ip_q;
    out_port_d = out_port_q;

    if (advance && !err_q) begin
      case (phase_q)
        PH_START, PH_OCTET: begin
          phase_d = PH_OCTET;
          if (!(phase_q == PH_START && in_char_q == CharDot)) begin
            if (is_digit) begin
              if (run_q >= RunMax) begin
                err_d = 1'b1;
              end else begin
                octet_d = OctetW'({octet_q, 3'b000}) + OctetW'({octet_q, 1'b0})
                          + OctetW'(digit);
                run_d   = run_q + 2'd1;
              end
            end else if (in_char_q == CharDot) begin
              do_close = 1'b1;
            end else if (in_char_q == CharColon) begin
              do_close = 1'b1;
              given_d  = 1'b1;
              phase_d  = PH_PORT;
            end else if (in_char_q == CharNul) begin
              do_close = 1'b1;
              phase_d  = PH_SKIP;
            end else begin
              err_d = 1'b1;
            end
          end
        end
        PH_PORT: begin
          if (is_digit) begin
            port_d = PortW'({port_q, 3'b000}) + PortW'({port_q, 1'b0}) + PortW'(digit);
          end else begin
            phase_d = PH_SKIP;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_close) begin
      if (octet_q > OctetMax) begin
        err_d = 1'b1;
      end else begin
        mask_d  = {mask_q[AddrW-9:0], 8'h00};
        accum_d = {accum_q[AddrW-9:0], octet_q[7:0]};
      end
      octet_d = '0;
      run_d   = '0;
    end

    if (advance && in_last_q) begin
      if (!err_d && (phase_d == PH_OCTET || phase_d == PH_START)) begin
        if (octet_d > OctetMax) begin
          err_d = 1'b1;
        end else begin
          mask_d  = {mask_d[AddrW-9:0], 8'h00};
          accum_d = {accum_d[AddrW-9:0], octet_d[7:0]};
        end
      end
      out_valid_d = 1'b1;
      out_ok_d    = !err_d;
      out_ip_d    = err_d ? '0 : ((local_addr_q & mask_d) | accum_d);
      out_port_d  = err_d ? '0 : (given_d ? port_d : default_port_q);
      phase_d = PH_START;
      octet_d = '0;
      run_d   = '0;
      accum_d = '0;
      mask_d  = '1;
      port_d  = '0;
      err_d   = 1'b0;
      given_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q   <= '0;
      default_port_q <= '0;
      in_valid_q     <= 1'b0;
      phase_q        <= PH_START;
      octet_q        <= '0;
      run_q          <= '0;
      accum_q        <= '0;
      mask_q         <= '1;
      port_q         <= '0;
      err_q          <= 1'b0;
      given_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        if (paddr[2] == RegLocalAddr) begin
          local_addr_q <= pwdata;
        end else begin
          default_port_q <= pwdata[PortW-1:0];
        end
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      phase_q     <= phase_d;
      octet_q     <= octet_d;
      run_q       <= run_d;
      accum_q     <= accum_d;
      mask_q      <= mask_d;
      port_q      <= port_d;
      err_q       <= err_d;
      given_q     <= given_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    out_ok_q   <= out_ok_d;
    out_ip_q   <= out_ip_d;
    out_port_q <= out_port_d;
  end

endmodule
`default_nettype wire

### rtl/core/pipv4_checker.sv
// Port-level checker for the partial IPv4 address parser, bound to the top level.
`default_nettype none
module pipv4_checker
  import pipv4_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              s_axis_tlast,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [OutTdW-1:0] m_axis_tdata
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction changed while stalled");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OutW-1:1] == '0)
    else $error("malformed result carries a non-zero address or port");

  a_rise_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result appeared without a last character two cycles earlier");

  a_pad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutTdW-1:OutW] == '0)
    else $error("result padding bits are not zero");

endmodule

bind partial_ipv4_address_parser pipv4_checker u_pipv4_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
